// ===== design/rgb565w_pkg.sv =====
`timescale 1ns / 1ps
package rgb565w_pkg;

    // Register field widths and APB geometry
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_ORG_W  = 12;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int ADDR_W     = 24;
    localparam int DATA_W     = 16;
    localparam int OPND_W     = 14;
    localparam int PROD_W     = OPND_W + CFG_DIM_W;
    localparam int DIM_MAX_REG = (1 << CFG_DIM_W) - 1;

    // Register indexes
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_PITCH      = 3'd2;
    localparam logic [2:0] REG_DST_ORIGIN_X   = 3'd3;
    localparam logic [2:0] REG_DST_ORIGIN_Y   = 3'd4;
    localparam logic [2:0] REG_SPAN_WIDTH     = 3'd5;
    localparam logic [2:0] REG_SPAN_HEIGHT    = 3'd6;

    // Request function codes
    localparam logic FUNC_BLIT = 1'b0;
    localparam logic FUNC_PLOT = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] surface_width;
        logic [CFG_DIM_W-1:0] surface_height;
        logic [CFG_DIM_W-1:0] dst_pitch;
        logic [CFG_ORG_W-1:0] dst_origin_x;
        logic [CFG_ORG_W-1:0] dst_origin_y;
        logic [CFG_DIM_W-1:0] span_width;
        logic [CFG_DIM_W-1:0] span_height;
    } t_cfg;

    // One write job: address = row_term * pitch + col_term
    typedef struct packed {
        logic [OPND_W-1:0] row_term;
        logic [OPND_W-1:0] col_term;
        logic [DATA_W-1:0] data;
        logic              end_of_blit;
    } t_op;

    function automatic logic [DATA_W-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        return {b[7:3], g[7:2], r[7:3]};
    endfunction

endpackage

// ===== design/rgb565w_if.sv =====
`timescale 1ns / 1ps
interface rgb565w_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    modport source (output valid, func, point_x, point_y, red, green, blue, input ready);
    modport sink   (input valid, func, point_x, point_y, red, green, blue, output ready);
endinterface

interface rgb565w_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] write_addr;
    logic [15:0] write_data;
    logic        end_of_blit;

    modport source (output valid, write_addr, write_data, end_of_blit, input ready);
    modport sink   (input valid, write_addr, write_data, end_of_blit, output ready);
endinterface

// ===== design/rgb565w_regs.sv =====
`timescale 1ns / 1ps
module rgb565w_regs
    import rgb565w_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_idx)
                REG_SURFACE_WIDTH:  n_cfg.surface_width  = pwdata[CFG_DIM_W-1:0];
                REG_SURFACE_HEIGHT: n_cfg.surface_height = pwdata[CFG_DIM_W-1:0];
                REG_DST_PITCH:      n_cfg.dst_pitch      = pwdata[CFG_DIM_W-1:0];
                REG_DST_ORIGIN_X:   n_cfg.dst_origin_x   = pwdata[CFG_ORG_W-1:0];
                REG_DST_ORIGIN_Y:   n_cfg.dst_origin_y   = pwdata[CFG_ORG_W-1:0];
                REG_SPAN_WIDTH:     n_cfg.span_width     = pwdata[CFG_DIM_W-1:0];
                REG_SPAN_HEIGHT:    n_cfg.span_height    = pwdata[CFG_DIM_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_SURFACE_WIDTH:  prdata = PDATA_W'(r_cfg.surface_width);
            REG_SURFACE_HEIGHT: prdata = PDATA_W'(r_cfg.surface_height);
            REG_DST_PITCH:      prdata = PDATA_W'(r_cfg.dst_pitch);
            REG_DST_ORIGIN_X:   prdata = PDATA_W'(r_cfg.dst_origin_x);
            REG_DST_ORIGIN_Y:   prdata = PDATA_W'(r_cfg.dst_origin_y);
            REG_SPAN_WIDTH:     prdata = PDATA_W'(r_cfg.span_width);
            REG_SPAN_HEIGHT:    prdata = PDATA_W'(r_cfg.span_height);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== design/rgb565w_front.sv =====
`timescale 1ns / 1ps
module rgb565w_front
    import rgb565w_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgb565w_in_if.sink   i_pix,
    input  t_cfg         i_cfg,
    input  logic         i_q_full,
    output logic         o_push,
    output t_op          o_op
);

    localparam int DIM_CAP = (MAX_DIM > DIM_MAX_REG) ? DIM_MAX_REG : MAX_DIM;

    logic [CFG_DIM_W-1:0] r_column_count, n_column_count;
    logic [CFG_DIM_W-1:0] r_row_count, n_row_count;

    logic [CFG_DIM_W-1:0] w_surf_w, w_surf_h, w_span_w, w_span_h;
    logic                 w_acc, w_plot_in, w_span_ok, w_line_end, w_rect_end;

    function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        return (v > CFG_DIM_W'(DIM_CAP)) ? CFG_DIM_W'(DIM_CAP) : v;
    endfunction

    assign w_surf_w = clamp_dim(i_cfg.surface_width);
    assign w_surf_h = clamp_dim(i_cfg.surface_height);
    assign w_span_w = clamp_dim(i_cfg.span_width);
    assign w_span_h = clamp_dim(i_cfg.span_height);

    assign i_pix.ready = !i_q_full;
    assign w_acc       = i_pix.valid && !i_q_full;

    // Drop points off the surface; negative coordinates fail on the sign bit
    assign w_plot_in = !i_pix.point_x[15] && !i_pix.point_y[15]
                    && (16'(i_pix.point_x) < 16'(w_surf_w))
                    && (16'(i_pix.point_y) < 16'(w_surf_h));

    assign w_span_ok  = (w_span_w != '0) && (w_span_h != '0);
    assign w_line_end = (OPND_W'(r_column_count) + OPND_W'(1)) >= OPND_W'(w_span_w);
    assign w_rect_end = w_line_end
                     && ((OPND_W'(r_row_count) + OPND_W'(1)) >= OPND_W'(w_span_h));

    always_comb begin
        o_op.data = pack565(i_pix.red, i_pix.green, i_pix.blue);
        if (i_pix.func == FUNC_PLOT) begin
            o_push           = w_acc && w_plot_in;
            o_op.row_term    = i_pix.point_y[OPND_W-1:0];
            o_op.col_term    = i_pix.point_x[OPND_W-1:0];
            o_op.end_of_blit = 1'b0;
        end else begin
            o_push           = w_acc && w_span_ok;
            o_op.row_term    = OPND_W'(i_cfg.dst_origin_y) + OPND_W'(r_row_count);
            o_op.col_term    = OPND_W'(i_cfg.dst_origin_x) + OPND_W'(r_column_count);
            o_op.end_of_blit = w_rect_end;
        end
    end

    // Advance the raster walk on every blit pixel that produces a write
    always_comb begin
        n_column_count = r_column_count;
        n_row_count    = r_row_count;
        if (w_acc && (i_pix.func == FUNC_BLIT) && w_span_ok) begin
            if (w_rect_end) begin
                n_column_count = '0;
                n_row_count    = '0;
            end else if (w_line_end) begin
                n_column_count = '0;
                n_row_count    = r_row_count + CFG_DIM_W'(1);
            end else begin
                n_column_count = r_column_count + CFG_DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= '0;
            r_row_count    <= '0;
        end else begin
            r_column_count <= n_column_count;
            r_row_count    <= n_row_count;
        end
    end

endmodule

// ===== design/rgb565w_queue.sv =====
`timescale 1ns / 1ps
module rgb565w_queue
    import rgb565w_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_op  o_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/rgb565w_back.sv =====
`timescale 1ns / 1ps
module rgb565w_back
    import rgb565w_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_op                  i_op,
    input  logic [CFG_DIM_W-1:0] i_pitch,
    output logic                 o_pop,
    rgb565w_out_if.source        o_wr
);

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_eob;
    logic [PROD_W-1:0] w_prod;
    logic [ADDR_W-1:0] w_addr;

    assign o_pop  = !i_q_empty && (!r_valid || o_wr.ready);
    assign w_prod = PROD_W'(i_op.row_term) * PROD_W'(i_pitch);
    assign w_addr = w_prod[ADDR_W-1:0] + ADDR_W'(i_op.col_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_wr.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= w_addr;
            r_data <= i_op.data;
            r_eob  <= i_op.end_of_blit;
        end
    end

    assign o_wr.valid       = r_valid;
    assign o_wr.write_addr  = r_addr;
    assign o_wr.write_data  = r_data;
    assign o_wr.end_of_blit = r_eob;

endmodule

// ===== design/rgb888_to_rgb565_pixel_writer_core.sv =====
`timescale 1ns / 1ps
// RGB888 to RGB565 pixel writer. Each request on i_pix is either a blit pixel
// (func = 0), walked in raster order over the span_width x span_height
// rectangle placed at dst_origin, or a plotted point (func = 1) clipped
// against surface_width x surface_height; a clipped point, or a blit pixel
// while the rectangle is empty, produces no write. Each write on o_wr carries
// the word address row * dst_pitch + column (modulo 2^24), the 5-6-5 word
// with red in the low bits and blue in the high bits, and end_of_blit on the
// rectangle's last pixel, after which the column and row counters are back at
// zero. While the queue has room and o_wr is ready, the block takes one
// request per clock and returns one write per clock: the front stage
// classifies a request and steps the raster counters in the cycle it is
// accepted, a two-entry queue decouples it from the back stage, and the back
// stage does the single 14 x 13 bit address multiply and add into the output
// register. Surface and span size registers above MAX_DIM act as MAX_DIM.
// Program the registers over the APB port (register n at byte address 4*n)
// only while no request is in flight; counters keep their place across writes.
module rgb888_to_rgb565_pixel_writer_core
    import rgb565w_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rgb565w_in_if.sink         i_pix,
    rgb565w_out_if.source      o_wr,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg w_cfg;
    t_op  w_push_op;
    t_op  w_head_op;
    logic w_push, w_pop, w_q_full, w_q_empty;

    // Configuration registers
    rgb565w_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Front: accept, clip or walk the rectangle, build the write job
    rgb565w_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (w_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    // Hold jobs while the back end stalls
    rgb565w_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_op    (w_head_op)
    );

    // Back: resolve the address and drive the write
    rgb565w_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_op      (w_head_op),
        .i_pitch   (w_cfg.dst_pitch),
        .o_pop     (w_pop),
        .o_wr      (o_wr)
    );

endmodule

// ===== design/rgb565w_checker.sv =====
`timescale 1ns / 1ps
module rgb565w_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_write_addr,
    input logic [15:0] i_write_data,
    input logic        i_end_of_blit
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // Reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("write valid after reset");

    // Queue and output register hold at most three writes; a ready receiver drains them
    a_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_acc && i_out_ready) ##1 (!w_in_acc && i_out_ready)
        ##1 (!w_in_acc && i_out_ready) |=> !i_out_valid)
        else $error("write appeared without a request");

    // A stalled write holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_write_addr)
            && $stable(i_write_data) && $stable(i_end_of_blit))
        else $error("stalled write changed");

endmodule

bind rgb888_to_rgb565_pixel_writer_core rgb565w_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_wr.valid),
    .i_out_ready   (o_wr.ready),
    .i_write_addr  (o_wr.write_addr),
    .i_write_data  (o_wr.write_data),
    .i_end_of_blit (o_wr.end_of_blit)
);

// ===== verif/rgb888_to_rgb565_pixel_writer_core_test.sv =====
`timescale 1ns / 1ps
module rgb888_to_rgb565_pixel_writer_core_test;
    import rgb565w_pkg::*;

    localparam int          DIM_LIMIT      = 4096;
    localparam int          ITEM_GOAL      = 1650;
    localparam int          QUIET_CYCLES   = 8;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          REPORT_LIMIT   = 10;
    // Index with no register behind it; writes to it must change nothing
    localparam logic [2:0]  REG_UNUSED     = 3'd7;

    typedef struct packed {
        logic        func;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_pix_req;

    typedef struct packed {
        logic [23:0] addr;
        logic [15:0] data;
        logic        eob;
    } t_mem_write;

    typedef enum logic {ROW_REG, ROW_PIX} t_row_kind;

    // One line of the directed script: either a register write or a request,
    // with a hand-written expectation where one is obvious
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_pix_req    req;
        bit          typed;
        bit          typed_has;
        t_mem_write  typed_w;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rgb565w_in_if  pix_if();
    rgb565w_out_if wr_if();

    rgb888_to_rgb565_pixel_writer_core #(
        .MAX_DIM (DIM_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_wr    (wr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Register shadow and raster position as the block should hold them
    t_cfg        cfg_shadow;
    logic [12:0] blit_col;
    logic [12:0] blit_row;

    // Memory writes still owed by the block, oldest first
    t_mem_write  pending[$];
    t_script_row script[$];

    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;
    int n_requests;
    int n_productive;
    int n_dropped;
    int n_rects;
    int n_checked;
    int n_settings;
    int n_errors;

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
    endfunction

    // Work out the write a request should cause, stepping the raster position
    // for blit pixels. Returns 0 when the request writes nothing.
    function automatic bit predict_write(input t_pix_req req, output t_mem_write w);
        int          px;
        int          py;
        int unsigned sw;
        int unsigned sh;
        int unsigned col;
        int unsigned row;
        int unsigned line_addr;
        bit          line_end;
        bit          rect_end;
        w.data = 16'(req.red >> 3) | (16'(req.green & 8'hFC) << 3)
               | (16'(req.blue & 8'hF8) << 8);
        w.addr = '0;
        w.eob  = 1'b0;
        if (req.func == FUNC_PLOT) begin
            px = int'($signed(req.x));
            py = int'($signed(req.y));
            if (px < 0 || py < 0)
                return 1'b0;
            if (px >= int'(clamp_dim(cfg_shadow.surface_width)) ||
                py >= int'(clamp_dim(cfg_shadow.surface_height)))
                return 1'b0;
            w.addr = 24'(px + py * int'(cfg_shadow.dst_pitch));
            return 1'b1;
        end
        sw = clamp_dim(cfg_shadow.span_width);
        sh = clamp_dim(cfg_shadow.span_height);
        if (sw == 0 || sh == 0)
            return 1'b0;
        col = blit_col;
        row = blit_row;
        line_addr = (int'(cfg_shadow.dst_origin_y) + row) * int'(cfg_shadow.dst_pitch)
                  + int'(cfg_shadow.dst_origin_x);
        w.addr = 24'(line_addr + col);
        // A counter pushed past a shrunken span still closes its line here
        line_end = (col + 1 >= sw);
        rect_end = line_end && (row + 1 >= sh);
        w.eob = rect_end;
        if (rect_end) begin
            blit_col = '0;
            blit_row = '0;
        end else if (line_end) begin
            blit_col = '0;
            blit_row = blit_row + 13'd1;
        end else begin
            blit_col = blit_col + 13'd1;
        end
        return 1'b1;
    endfunction

    function automatic t_pix_req make_req(input logic func, input int x, input int y,
                                          input logic [23:0] rgb);
        t_pix_req r;
        r.func  = func;
        r.x     = 16'(x);
        r.y     = 16'(y);
        r.red   = rgb[23:16];
        r.green = rgb[15:8];
        r.blue  = rgb[7:0];
        return r;
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [31:0] val);
        t_script_row s;
        s = '{kind: ROW_REG, default: '0};
        s.kind    = ROW_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        script.push_back(s);
    endfunction

    function automatic void add_pix(input logic func, input int x, input int y,
                                    input logic [23:0] rgb, input bit typed, input bit has,
                                    input logic [23:0] addr, input logic [15:0] data,
                                    input bit eob);
        t_script_row s;
        s = '{kind: ROW_PIX, default: '0};
        s.kind      = ROW_PIX;
        s.req       = make_req(func, x, y, rgb);
        s.typed     = typed;
        s.typed_has = has;
        s.typed_w   = '{addr: addr, data: data, eob: eob};
        script.push_back(s);
    endfunction

    // Run-length split of the idling: sender light / receiver heavy, then
    // swapped, then full rate on both sides
    function automatic void set_idle_mode();
        if (n_requests < ITEM_GOAL / 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 82;
        end else if (n_requests < 2 * ITEM_GOAL / 3) begin
            send_idle_pct = 82;
            recv_idle_pct = 13;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // APB write: setup cycle, access cycle, register lands on the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SURFACE_WIDTH:  cfg_shadow.surface_width  = val[CFG_DIM_W-1:0];
            REG_SURFACE_HEIGHT: cfg_shadow.surface_height = val[CFG_DIM_W-1:0];
            REG_DST_PITCH:      cfg_shadow.dst_pitch      = val[CFG_DIM_W-1:0];
            REG_DST_ORIGIN_X:   cfg_shadow.dst_origin_x   = val[CFG_ORG_W-1:0];
            REG_DST_ORIGIN_Y:   cfg_shadow.dst_origin_y   = val[CFG_ORG_W-1:0];
            REG_SPAN_WIDTH:     cfg_shadow.span_width     = val[CFG_DIM_W-1:0];
            REG_SPAN_HEIGHT:    cfg_shadow.span_height    = val[CFG_DIM_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one request, hold it until taken, then book the write it owes.
    // A typed row books the hand-written expectation but still advances the
    // raster position.
    task automatic send_request(input t_pix_req req, input bit typed, input bit typed_has,
                                input t_mem_write typed_w);
        t_mem_write w;
        bit         has;
        set_idle_mode();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.func    <= req.func;
        pix_if.point_x <= req.x;
        pix_if.point_y <= req.y;
        pix_if.red     <= req.red;
        pix_if.green   <= req.green;
        pix_if.blue    <= req.blue;
        do @(posedge i_clk); while (!pix_if.ready);
        has = predict_write(req, w);
        if (typed) begin
            has = typed_has;
            w   = typed_w;
        end
        n_requests++;
        if (has) begin
            pending.push_back(w);
            n_productive++;
            if (w.eob)
                n_rects++;
        end else begin
            n_dropped++;
        end
    endtask

    // Drop valid, drain every owed write, then let dropped requests clear
    // the pipe before the registers move
    task automatic wait_quiet();
        pix_if.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [12:0] pick_dim(input int unsigned typical);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 13'(DIM_LIMIT);
            2:       return 13'($urandom_range(DIM_LIMIT + 1, 8191));
            3, 4:    return 13'($urandom_range(1, DIM_LIMIT));
            default: return 13'($urandom_range(1, typical));
        endcase
    endfunction

    // Coordinate mostly inside [0, lim), sometimes on or past the edge,
    // negative, or anywhere in the 16-bit range
    function automatic logic [15:0] pick_coord(input int unsigned lim);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return (lim == 0) ? 16'($urandom()) : 16'($urandom_range(0, lim - 1));
            6:       return 16'(lim);
            7:       return (lim == 0) ? 16'd0 : 16'(lim - 1);
            8:       return 16'($urandom_range(32768, 65535));
            default: return 16'($urandom());
        endcase
    endfunction

    // Random upper bits above the register fields; the block must drop them
    function automatic logic [31:0] dirty(input logic [12:0] v);
        logic [31:0] junk;
        junk = $urandom();
        return $urandom_range(0, 1) ? {junk[31:13], v} : {19'd0, v};
    endfunction

    // Receiver: stall at random, at the rate the current mode asks
    initial begin
        wr_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            wr_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every accepted write against the oldest owed one, and track how
    // long nothing has moved on any port
    always @(posedge i_clk) begin : wr_check
        t_mem_write want;
        if (wr_if.valid && wr_if.ready) begin
            n_checked++;
            if (pending.size() == 0) begin
                if (n_errors < REPORT_LIMIT)
                    $display("write with nothing owed: addr %h data %h eob %b",
                             wr_if.write_addr, wr_if.write_data, wr_if.end_of_blit);
                n_errors++;
            end else begin
                want = pending.pop_front();
                if (wr_if.write_addr !== want.addr || wr_if.write_data !== want.data ||
                    wr_if.end_of_blit !== want.eob) begin
                    if (n_errors < REPORT_LIMIT)
                        $display("write mismatch at %0t: addr %h/%h data %h/%h eob %b/%b",
                                 $realtime, want.addr, wr_if.write_addr, want.data,
                                 wr_if.write_data, want.eob, wr_if.end_of_blit);
                    n_errors++;
                end
            end
        end
        if ((wr_if.valid && wr_if.ready) || (pix_if.valid && pix_if.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Hang guard: too long with no handshake anywhere
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("watchdog: %0d cycles with no traffic, %0d writes still owed",
                 WATCHDOG_LIMIT, pending.size());
        $display("[rgb888_to_rgb565_pixel_writer_core] ERROR");
        $finish;
    end

    initial begin
        t_pix_req    req;
        t_mem_write  none;
        t_script_row s;
        bit          last_pix;
        int          rect;
        int          n_blits;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.func    <= FUNC_BLIT;
        pix_if.point_x <= '0;
        pix_if.point_y <= '0;
        pix_if.red     <= '0;
        pix_if.green   <= '0;
        pix_if.blue    <= '0;
        cfg_shadow    = '0;
        blit_col      = '0;
        blit_row      = '0;
        idle_cycles   = 0;
        n_requests    = 0;
        n_productive  = 0;
        n_dropped     = 0;
        n_rects       = 0;
        n_checked     = 0;
        n_settings    = 0;
        n_errors      = 0;
        none          = '0;
        set_idle_mode();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset every register is zero: empty rectangle, no surface
        add_pix(FUNC_BLIT, 0, 0, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_PLOT, 0, 0, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        // Unmapped index first; then an oversized width that must act as 4096
        add_reg(REG_UNUSED, 32'hFFFF_FFFF);
        add_reg(REG_SURFACE_WIDTH, 32'd8191);
        add_reg(REG_SURFACE_HEIGHT, 32'd4096);
        add_reg(REG_DST_PITCH, 32'd4096);
        add_reg(REG_DST_ORIGIN_X, 32'd0);
        add_reg(REG_DST_ORIGIN_Y, 32'd0);
        add_reg(REG_SPAN_WIDTH, 32'd2);
        add_reg(REG_SPAN_HEIGHT, 32'd2);
        // Points at the corners and one colour channel at a time
        add_pix(FUNC_PLOT, 0, 0, 24'h000000, 1, 1, 24'h000000, 16'h0000, 0);
        add_pix(FUNC_PLOT, 4095, 4095, 24'hFFFFFF, 1, 1, 24'hFFFFFF, 16'hFFFF, 0);
        add_pix(FUNC_PLOT, 1, 0, 24'hFF0000, 1, 1, 24'h000001, 16'h001F, 0);
        add_pix(FUNC_PLOT, 0, 1, 24'h00FF00, 1, 1, 24'h001000, 16'h07E0, 0);
        add_pix(FUNC_PLOT, 2, 3, 24'h0000FF, 1, 1, 24'h003002, 16'hF800, 0);
        // Points off the surface: past each edge, negative, far out
        add_pix(FUNC_PLOT, 4096, 0, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_PLOT, 0, 4096, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_PLOT, -1, 5, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_PLOT, 5, -32768, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_PLOT, 32767, 32767, 24'hFFFFFF, 1, 0, 24'h0, 16'h0, 0);
        // A full 2 x 2 rectangle, end flag on the last pixel
        add_pix(FUNC_BLIT, 0, 0, 24'hFFFFFF, 1, 1, 24'h000000, 16'hFFFF, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'h070307, 1, 1, 24'h000001, 16'h0000, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'hFFFFFF, 1, 1, 24'h001000, 16'hFFFF, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'h000000, 1, 1, 24'h001001, 16'h0000, 1);
        // Shrink the span under a running column counter
        add_reg(REG_SPAN_WIDTH, 32'd4);
        add_reg(REG_SPAN_HEIGHT, 32'd3);
        add_pix(FUNC_BLIT, 0, 0, 24'h123456, 0, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'h89ABCD, 0, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'hFEDCBA, 0, 0, 24'h0, 16'h0, 0);
        add_reg(REG_SPAN_WIDTH, 32'd2);
        add_pix(FUNC_BLIT, 0, 0, 24'h5A5A5A, 0, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'hA5A5A5, 0, 0, 24'h0, 16'h0, 0);
        // Empty rectangle: nothing written, counters hold
        add_reg(REG_SPAN_HEIGHT, 32'd0);
        add_pix(FUNC_BLIT, 0, 0, 24'hFFFFFF, 0, 0, 24'h0, 16'h0, 0);
        // Far corner origin: address wraps past 2^24
        add_reg(REG_DST_ORIGIN_X, 32'd4095);
        add_reg(REG_DST_ORIGIN_Y, 32'd4095);
        add_reg(REG_SPAN_WIDTH, 32'd1);
        add_reg(REG_SPAN_HEIGHT, 32'd8191);
        add_pix(FUNC_BLIT, 0, 0, 24'h00FF00, 0, 0, 24'h0, 16'h0, 0);
        add_pix(FUNC_BLIT, 0, 0, 24'hFF00FF, 0, 0, 24'h0, 16'h0, 0);
        // Row counter now past a one-row span: closes the rectangle at once
        add_reg(REG_SPAN_HEIGHT, 32'd1);
        add_pix(FUNC_BLIT, 0, 0, 24'h808080, 0, 0, 24'h0, 16'h0, 0);

        last_pix = 1'b0;
        foreach (script[i]) begin
            s = script[i];
            if (s.kind == ROW_REG) begin
                if (last_pix) begin
                    wait_quiet();
                    n_settings++;
                end
                write_reg(s.reg_idx, s.reg_val);
                last_pix = 1'b0;
            end else begin
                send_request(s.req, s.typed, s.typed_has, s.typed_w);
                last_pix = 1'b1;
            end
        end

        // Random settings, each followed by whole rectangles of random pixels
        // with points mixed in; now and then stop mid-rectangle so the next
        // setting starts from a stranded counter
        while (n_requests < ITEM_GOAL) begin
            wait_quiet();
            n_settings++;
            write_reg(REG_SURFACE_WIDTH, dirty(pick_dim(64)));
            write_reg(REG_SURFACE_HEIGHT, dirty(pick_dim(64)));
            case ($urandom_range(0, 9))
                0:       write_reg(REG_DST_PITCH, dirty(13'd0));
                1:       write_reg(REG_DST_PITCH, dirty(13'd4096));
                2:       write_reg(REG_DST_PITCH, dirty(13'd8191));
                3, 4:    write_reg(REG_DST_PITCH, dirty(13'($urandom_range(1, 4096))));
                default: write_reg(REG_DST_PITCH, dirty(13'($urandom_range(1, 128))));
            endcase
            write_reg(REG_DST_ORIGIN_X, dirty(13'($urandom_range(0, 8191))));
            write_reg(REG_DST_ORIGIN_Y, dirty(13'($urandom_range(0, 8191))));
            write_reg(REG_SPAN_WIDTH, dirty(pick_dim(8)));
            write_reg(REG_SPAN_HEIGHT, dirty(pick_dim(8)));
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_UNUSED, $urandom());

            rect = clamp_dim(cfg_shadow.span_width) * clamp_dim(cfg_shadow.span_height);
            if (rect != 0 && rect <= 64)
                n_blits = rect * $urandom_range(1, 3);
            else
                n_blits = $urandom_range(16, 48);
            if ($urandom_range(0, 4) == 0)
                n_blits += $urandom_range(1, 5);

            while (n_blits > 0) begin
                req.red   = $urandom();
                req.green = $urandom();
                req.blue  = $urandom();
                if ($urandom_range(0, 3) == 0) begin
                    req.func = FUNC_PLOT;
                    req.x    = pick_coord(clamp_dim(cfg_shadow.surface_width));
                    req.y    = pick_coord(clamp_dim(cfg_shadow.surface_height));
                end else begin
                    // Point fields are don't-care on blits; keep them moving
                    req.func = FUNC_BLIT;
                    req.x    = $urandom();
                    req.y    = $urandom();
                    n_blits--;
                end
                send_request(req, 1'b0, 1'b0, none);
            end
        end

        pix_if.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests over %0d register settings: %0d writes checked,",
                 n_requests, n_settings, n_checked);
        $display("%0d rectangles closed, %0d requests dropped, %0d mismatches",
                 n_rects, n_dropped, n_errors);
        if (n_errors == 0 && pending.size() == 0)
            $display("[rgb888_to_rgb565_pixel_writer_core] OK");
        else
            $display("[rgb888_to_rgb565_pixel_writer_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/rgb565w_pkg.sv
design/rgb565w_if.sv
design/rgb565w_regs.sv
design/rgb565w_front.sv
design/rgb565w_queue.sv
design/rgb565w_back.sv
design/rgb888_to_rgb565_pixel_writer_core.sv
design/rgb565w_checker.sv
verif/rgb888_to_rgb565_pixel_writer_core_test.sv
